// ----- rtl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, action codes, state type and control structs of the
// bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int MAP_WORDS = 64;
  localparam int DATA_W    = 64;
  localparam int BIT_W     = 6;
  localparam int ACT_W     = 3;
  localparam int WORD_W    = 6;
  localparam int LOW_W     = 13;
  localparam int SLOT_W    = 12;
  localparam int CFG_W     = 7;
  localparam int CFG_RESET = 64;

  localparam int WA_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WC_W  = $clog2(MAP_WORDS + 1);
  localparam int PTR_W = (WC_W > CFG_W) ? WC_W : CFG_W;

  localparam logic [ACT_W-1:0] ACT_FIND     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FIND_CLR = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RANGE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FREE     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_USED     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TEST     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_EVAL,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_first;
    logic rd_next;
    logic eval;
    logic write;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic more;
    logic need_wr;
    logic rsp_busy;
  } status_t;

endpackage

// ----- rtl/bsa_ifs.sv -----
// ----------------------------------------------------------------------------
// bsa_ifs
// Request, response and configuration channels of the slot allocator.
// ----------------------------------------------------------------------------
interface bsa_req_if import bsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [WORD_W-1:0]       start_word;
  logic signed [LOW_W-1:0] low_bit;
  logic [SLOT_W-1:0]       high_bit;
  logic [SLOT_W-1:0]       bit_index;

  modport source (output valid, action, start_word, low_bit, high_bit, bit_index,
                  input ready);
  modport sink   (input valid, action, start_word, low_bit, high_bit, bit_index,
                  output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [SLOT_W-1:0] bit_offset;

  modport source (output valid, ok, bit_offset, input ready);
  modport sink   (input valid, ok, bit_offset, output ready);
endinterface

interface bsa_cfg_if import bsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/bitmap64_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap64_slot_allocator
// Free slot allocator over a bitmap of 64-bit words, one request at a time.
// ----------------------------------------------------------------------------
// One request is handled at a time. After acceptance it passes a start state,
// then reads and evaluates map words, one per cycle through the single read
// port of the map RAM, then a write-back state when the map is changed, and
// a done state that loads the result once the output register is free. The
// sequencer returns to idle before the next request is taken. A new request
// is accepted while the previous result still waits in the output register.
// After reset every slot reads as used at once, with no clearing pass;
// words_in_use may be written at any cycle while no request is in flight.
module bitmap64_slot_allocator import bsa_pkg::*; (
  input logic       clk,
  input logic       rst,
  bsa_req_if.sink   req,
  bsa_rsp_if.source rsp,
  bsa_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t st;

  assign cfg.ready = 1'b1;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bsa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .req_action     (req.action),
    .req_start_word (req.start_word),
    .req_low_bit    (req.low_bit),
    .req_high_bit   (req.high_bit),
    .req_bit_index  (req.bit_index),
    .cfg_valid      (cfg.valid),
    .cfg_data       (cfg.data),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ok         (rsp.ok),
    .rsp_bit_offset (rsp.bit_offset)
  );

endmodule

// ----- rtl/bsa_ram.sv -----
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer of the slot allocator: accept, word scan, write back, result.
// ----------------------------------------------------------------------------
module bsa_ctrl import bsa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (st.go) begin
          cmd.rd_first = 1'b1;
          state_next   = ST_EVAL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (st.more) begin
          cmd.rd_next = 1'b1;
        end else if (st.need_wr) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!st.rsp_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/bsa_dp.sv -----
// ----------------------------------------------------------------------------
// bsa_dp
// Datapath of the slot allocator: request registers, free map, word
// evaluation and the response register.
// ----------------------------------------------------------------------------
module bsa_dp import bsa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output status_t                 st,
  input  logic [ACT_W-1:0]        req_action,
  input  logic [WORD_W-1:0]       req_start_word,
  input  logic signed [LOW_W-1:0] req_low_bit,
  input  logic [SLOT_W-1:0]       req_high_bit,
  input  logic [SLOT_W-1:0]       req_bit_index,
  input  logic                    cfg_valid,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    rsp_ready,
  output logic                    rsp_valid,
  output logic                    rsp_ok,
  output logic [SLOT_W-1:0]       rsp_bit_offset
);

  localparam int FULL_W = PTR_W + BIT_W;

  function automatic logic [BIT_W-1:0] lowest_one(input logic [DATA_W-1:0] v);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = BIT_W'(i);
      end
    end
    return n;
  endfunction

  logic [CFG_W-1:0]     words_in_use;
  logic [ACT_W-1:0]     act;
  logic [SLOT_W-1:0]    high;
  logic [PTR_W-1:0]     cur;
  logic [PTR_W-1:0]     last;
  logic [DATA_W-1:0]    mask;
  logic                 first;
  logic                 go;
  logic                 rd_vld;
  logic                 ok_r;
  logic [SLOT_W-1:0]    off_r;
  logic [DATA_W-1:0]    wdata;
  logic [MAP_WORDS-1:0] word_vld;

  logic [PTR_W-1:0]   count;
  logic [SLOT_W:0]    next_lo;
  logic [PTR_W-1:0]   hi_end;
  logic [PTR_W-1:0]   a_cur;
  logic [PTR_W-1:0]   a_end;
  logic [DATA_W-1:0]  a_mask;

  logic [PTR_W-1:0]   rd_ptr;
  logic               re;
  logic [DATA_W-1:0]  rd_data;
  logic [DATA_W-1:0]  word;
  logic [DATA_W-1:0]  v;
  logic               hit;
  logic               bitset;
  logic [BIT_W-1:0]   b;
  logic [FULL_W-1:0]  slot_full;
  logic               search;
  logic               ev_ok;
  logic               ev_wr;
  logic [DATA_W-1:0]  ev_wdata;
  logic [PTR_W:0]     cur_inc;

  // request decode
  always_comb begin
    count   = (PTR_W'(words_in_use) > PTR_W'(MAP_WORDS)) ? PTR_W'(MAP_WORDS)
                                                          : PTR_W'(words_in_use);
    next_lo = {1'b0, req_low_bit[SLOT_W-1:0]} + (SLOT_W + 1)'(1);
    hi_end  = PTR_W'(req_high_bit[SLOT_W-1:BIT_W]) + PTR_W'(1);
    a_cur   = '0;
    a_end   = '0;
    a_mask  = '1;
    unique case (req_action)
      ACT_FIND, ACT_FIND_CLR: begin
        a_cur = PTR_W'(req_start_word);
        a_end = count;
      end
      ACT_RANGE: begin
        if (!req_low_bit[LOW_W-1]) begin
          a_cur  = PTR_W'(next_lo[SLOT_W:BIT_W]);
          a_mask = {DATA_W{1'b1}} << next_lo[BIT_W-1:0];
        end
        a_end = (hi_end < count) ? hi_end : count;
      end
      ACT_FREE, ACT_USED, ACT_TEST: begin
        a_cur  = PTR_W'(req_bit_index[SLOT_W-1:BIT_W]);
        a_end  = count;
        a_mask = DATA_W'(1) << req_bit_index[BIT_W-1:0];
      end
      default: begin
        a_cur = '0;
        a_end = '0;
      end
    endcase
  end

  // map read
  assign cur_inc = {1'b0, cur} + (PTR_W + 1)'(1);
  assign rd_ptr  = cmd.rd_next ? cur_inc[PTR_W-1:0] : cur;
  assign re      = cmd.rd_first | cmd.rd_next;

  bsa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (cur[WA_W-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_ptr[WA_W-1:0]),
    .rdata (rd_data)
  );

  // word evaluation
  always_comb begin
    word      = rd_vld ? rd_data : '0;
    search    = (act == ACT_FIND) || (act == ACT_FIND_CLR) || (act == ACT_RANGE);
    v         = first ? (word & mask) : word;
    hit       = |v;
    b         = lowest_one(v);
    slot_full = {cur, b};
    bitset    = |(word & mask);
    ev_ok     = 1'b0;
    ev_wr     = 1'b0;
    ev_wdata  = word;
    unique case (act)
      ACT_FIND: ev_ok = hit;
      ACT_FIND_CLR: begin
        ev_ok    = hit;
        ev_wr    = hit;
        ev_wdata = word & ~(DATA_W'(1) << b);
      end
      ACT_RANGE: ev_ok = hit && (slot_full <= FULL_W'(high));
      ACT_FREE: begin
        ev_ok    = !bitset;
        ev_wr    = !bitset;
        ev_wdata = word | mask;
      end
      ACT_USED: begin
        ev_ok    = bitset;
        ev_wr    = bitset;
        ev_wdata = word & ~mask;
      end
      ACT_TEST: ev_ok = bitset;
      default: ev_ok = 1'b0;
    endcase
  end

  assign st.go       = go;
  assign st.more     = search && !hit && (cur_inc < {1'b0, last});
  assign st.need_wr  = ev_wr;
  assign st.rsp_busy = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= CFG_W'(CFG_RESET);
      word_vld     <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        words_in_use <= cfg_data;
      end
      if (cmd.write) begin
        word_vld[cur[WA_W-1:0]] <= 1'b1;
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act   <= req_action;
      high  <= req_high_bit;
      cur   <= a_cur;
      last  <= a_end;
      mask  <= a_mask;
      first <= 1'b1;
      go    <= a_cur < a_end;
      ok_r  <= 1'b0;
      off_r <= '0;
    end
    if (re) begin
      rd_vld <= (rd_ptr < PTR_W'(MAP_WORDS)) && word_vld[rd_ptr[WA_W-1:0]];
    end
    if (cmd.eval) begin
      if (st.more) begin
        cur   <= cur_inc[PTR_W-1:0];
        first <= 1'b0;
      end else begin
        ok_r  <= ev_ok;
        off_r <= (ev_ok && search) ? slot_full[SLOT_W-1:0] : '0;
        wdata <= ev_wdata;
      end
    end
    if (cmd.finish) begin
      rsp_ok         <= ok_r;
      rsp_bit_offset <= off_r;
    end
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the bitmap slot allocator against a behavioural copy of its free map.
// A queue of requests feeds a clocked driver. Each accepted request updates the
// copy and yields the expected response. A clocked monitor compares every
// response, field by field, against the oldest expected one. Phases run at
// several words_in_use settings and with changing idle patterns.
// ----------------------------------------------------------------------------
module tb import bsa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACT_W-1:0] ACT_UNDEF_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNDEF_B = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [WORD_W-1:0]       start_word;
    logic signed [LOW_W-1:0] low_bit;
    logic [SLOT_W-1:0]       high_bit;
    logic [SLOT_W-1:0]       bit_index;
  } slot_req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] bit_offset;
  } slot_rsp_t;

  logic clk;
  logic rst;

  bsa_req_if req_ch ();
  bsa_rsp_if rsp_ch ();
  bsa_cfg_if cfg_ch ();

  bitmap64_slot_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  logic [DATA_W-1:0] free_copy [MAP_WORDS] = '{default: '0};
  logic [CFG_W-1:0]  words_copy;

  slot_req_t req_queue [$];
  slot_rsp_t rsp_expected [$];
  slot_rsp_t want_rsp;

  int err_count = 0;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_token;
  int hold_seen;
  int hold_left;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Applies one request to the free map copy and returns the response it causes.
  function automatic slot_rsp_t slot_outcome(input slot_req_t r);
    slot_rsp_t res;
    int count;
    int first;
    int last;
    int nxt;
    int word;
    int lowest;
    int slot;
    logic found;
    logic search;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] v;
    count = (words_copy > MAP_WORDS) ? MAP_WORDS : int'(words_copy);
    res = '0;
    found = 1'b0;
    search = 1'b0;
    slot = 0;
    first = 0;
    last = 0;
    mask = '1;
    word = int'(r.bit_index >> BIT_W);
    case (r.action)
      ACT_FIND, ACT_FIND_CLR: begin
        search = 1'b1;
        first = int'(r.start_word);
        last = count;
      end
      ACT_RANGE: begin
        search = 1'b1;
        last = int'(r.high_bit >> BIT_W) + 1;
        if (!r.low_bit[LOW_W-1]) begin
          nxt = int'(r.low_bit[SLOT_W-1:0]) + 1;
          first = nxt >> BIT_W;
          mask = mask << nxt[BIT_W-1:0];
        end
        if (last > count) last = count;
      end
      ACT_FREE: begin
        if (word < count && !free_copy[word][r.bit_index[BIT_W-1:0]]) begin
          free_copy[word][r.bit_index[BIT_W-1:0]] = 1'b1;
          res.ok = 1'b1;
        end
      end
      ACT_USED: begin
        if (word < count && free_copy[word][r.bit_index[BIT_W-1:0]]) begin
          free_copy[word][r.bit_index[BIT_W-1:0]] = 1'b0;
          res.ok = 1'b1;
        end
      end
      ACT_TEST: begin
        if (word < count) res.ok = free_copy[word][r.bit_index[BIT_W-1:0]];
      end
      default: ;
    endcase
    if (search) begin
      for (int w = first; w < last && w < MAP_WORDS; w++) begin
        if (!found) begin
          v = free_copy[w];
          if (w == first) v &= mask;
          if (v != '0) begin
            lowest = 0;
            for (int k = DATA_W - 1; k >= 0; k--) if (v[k]) lowest = k;
            if (r.action == ACT_FIND_CLR) free_copy[w][lowest] = 1'b0;
            slot = w * DATA_W + lowest;
            found = 1'b1;
          end
        end
      end
      if (found && r.action == ACT_RANGE && slot > int'(r.high_bit)) found = 1'b0;
      res.ok = found;
      res.bit_offset = found ? SLOT_W'(slot) : '0;
    end
    return res;
  endfunction

  task automatic push_req(input logic [ACT_W-1:0] act, input int start, input int low,
                          input int high, input int idx);
    slot_req_t r;
    r.action = act;
    r.start_word = WORD_W'(start);
    r.low_bit = LOW_W'(low);
    r.high_bit = SLOT_W'(high);
    r.bit_index = SLOT_W'(idx);
    req_queue.push_back(r);
  endtask

  // Mostly well-formed requests aimed at the managed words, some noise.
  function automatic slot_req_t rand_request();
    slot_req_t r;
    int words;
    int span;
    int pick;
    int lo;
    int hi;
    words = (words_copy == 0 || words_copy > MAP_WORDS) ? MAP_WORDS : int'(words_copy);
    span = words * DATA_W;
    r.action = ACT_W'($urandom_range(5));
    r.start_word = WORD_W'($urandom);
    r.low_bit = ($urandom_range(3) == 0) ? LOW_W'(-1) : LOW_W'($urandom_range(4095));
    r.high_bit = SLOT_W'($urandom);
    r.bit_index = SLOT_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.action = ACT_FREE;
      if ($urandom_range(9) != 0) r.bit_index = SLOT_W'($urandom_range(span - 1));
    end else if (pick < 42) begin
      r.action = ACT_USED;
      if ($urandom_range(9) != 0) r.bit_index = SLOT_W'($urandom_range(span - 1));
    end else if (pick < 55) begin
      r.action = ACT_TEST;
      if ($urandom_range(9) != 0) r.bit_index = SLOT_W'($urandom_range(span - 1));
    end else if (pick < 70) begin
      r.action = ACT_FIND;
      if ($urandom_range(9) != 0) r.start_word = WORD_W'($urandom_range(words - 1));
    end else if (pick < 80) begin
      r.action = ACT_FIND_CLR;
      if ($urandom_range(9) != 0) r.start_word = WORD_W'($urandom_range(words - 1));
    end else if (pick < 97) begin
      r.action = ACT_RANGE;
      lo = ($urandom_range(9) == 0) ? -1 : int'($urandom_range(span - 1));
      hi = lo + int'($urandom_range(400, 1));
      if (hi > 4095) hi = 4095;
      if ($urandom_range(9) == 0) hi = int'($urandom_range(4095));
      r.low_bit = LOW_W'(lo);
      r.high_bit = SLOT_W'(hi);
    end else begin
      r.action = ACT_W'($urandom_range(7));
    end
    return r;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (req_queue.size() != 0 || req_ch.valid || rsp_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_words(input int value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= CFG_W'(value);
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    words_copy = CFG_W'(value);
    @(negedge clk);
  endtask

  task automatic run_phase(input int words, input int n, input int src_pct,
                           input int snk_pct);
    write_words(words);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) req_queue.push_back(rand_request());
    wait_drained();
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.action <= '0;
      req_ch.start_word <= '0;
      req_ch.low_bit <= '0;
      req_ch.high_bit <= '0;
      req_ch.bit_index <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        rsp_expected.push_back(slot_outcome('{req_ch.action, req_ch.start_word,
                                              req_ch.low_bit, req_ch.high_bit,
                                              req_ch.bit_index}));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          slot_req_t r;
          r = req_queue.pop_front();
          req_ch.action <= r.action;
          req_ch.start_word <= r.start_word;
          req_ch.low_bit <= r.low_bit;
          req_ch.high_bit <= r.high_bit;
          req_ch.bit_index <= r.bit_index;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (rsp_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected response ok=%0d offset=%0d",
                                    rsp_ch.ok, rsp_ch.bit_offset));
        end else begin
          want_rsp = rsp_expected.pop_front();
          if (rsp_ch.ok !== want_rsp.ok)
            report_mismatch($sformatf("ok %0d, expected %0d", rsp_ch.ok, want_rsp.ok));
          if (rsp_ch.bit_offset !== want_rsp.bit_offset)
            report_mismatch($sformatf("bit_offset %0d, expected %0d",
                                      rsp_ch.bit_offset, want_rsp.bit_offset));
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", stall_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    hold_token = 0;
    src_idle_pct = 20;
    snk_idle_pct = 53;
    words_copy = CFG_W'(CFG_RESET);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // map starts all used
    push_req(ACT_TEST, 0, 0, 0, 0);
    push_req(ACT_FIND, 0, 0, 0, 0);
    push_req(ACT_RANGE, 0, -1, 4095, 0);
    push_req(ACT_FREE, 0, 0, 0, 0);
    push_req(ACT_FREE, 0, 0, 0, 0);
    push_req(ACT_FREE, 0, 0, 0, 4095);
    push_req(ACT_FREE, 0, 0, 0, 2730);
    push_req(ACT_FREE, 0, 0, 0, 1365);
    push_req(ACT_TEST, 0, 0, 0, 4095);
    push_req(ACT_TEST, 0, 0, 0, 1);
    push_req(ACT_FIND, 0, 0, 0, 0);
    push_req(ACT_FIND, 63, 0, 0, 0);
    push_req(ACT_FIND_CLR, 0, 0, 0, 0);
    push_req(ACT_FIND, 0, 0, 0, 0);
    push_req(ACT_RANGE, 0, -1, 4095, 0);
    push_req(ACT_RANGE, 0, 1365, 4095, 0);
    push_req(ACT_RANGE, 0, 2730, 2730, 0);
    push_req(ACT_RANGE, 0, 4095, 4095, 0);
    push_req(ACT_RANGE, 0, 0, 1364, 0);
    push_req(ACT_USED, 0, 0, 0, 1365);
    push_req(ACT_USED, 0, 0, 0, 1365);
    push_req(ACT_UNDEF_A, 63, 4095, 4095, 4095);
    push_req(ACT_UNDEF_B, 0, -1, 0, 2730);
    wait_drained();

    // single managed word: everything beyond word 0 is out of range
    write_words(1);
    push_req(ACT_FIND, 1, 0, 0, 0);
    push_req(ACT_FREE, 0, 0, 0, 64);
    push_req(ACT_TEST, 0, 0, 0, 4095);
    push_req(ACT_FREE, 0, 0, 0, 5);
    push_req(ACT_RANGE, 0, 3, 4095, 0);
    wait_drained();

    // receiver holds off while the queue keeps the input busy
    write_words(64);
    src_idle_pct = 20;
    snk_idle_pct = 53;
    repeat (250) req_queue.push_back(rand_request());
    hold_token++;
    wait_drained();

    run_phase(1, 120, 20, 53);
    run_phase(0, 30, 53, 20);
    run_phase(127, 200, 53, 20);
    run_phase(13, 150, 53, 20);
    run_phase(64, 200, 0, 0);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
